// File: rtl/core/pvr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvr_pkg
// Shared types, widths and helper functions of the Park vector rotator.
// ----------------------------------------------------------------------------
package pvr_pkg;

   // fixed widths of the request and response fields
   localparam int DATA_WIDTH = 16;
   localparam int ANGLE_WIDTH = 16;

   // sine table: Q1.15 magnitudes, 15 bits hold 0 .. 32767
   localparam int TABLE_ADDR_BITS_DEFAULT = 10;
   localparam int SINE_WIDTH = 16;
   localparam int SINE_MAG_WIDTH = SINE_WIDTH - 1;
   localparam int FRAC_BITS = 15;

   // cycles from an accepted request to its response strobe
   localparam int LATENCY = 5;

   // operation codes
   localparam logic FUNC_FORWARD = 1'b0;
   localparam logic FUNC_INVERSE = 1'b1;

   typedef struct packed {
      logic                          func;
      logic signed [DATA_WIDTH-1:0]  in_x;
      logic signed [DATA_WIDTH-1:0]  in_y;
      logic [ANGLE_WIDTH-1:0]        angle;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0]  out_x;
      logic signed [DATA_WIDTH-1:0]  out_y;
   } rsp_type;

   // one sine table entry, round(32768 * sin(pi/2 * k / 2^addr_bits)),
   // from a Taylor series in Q30; evaluated at elaboration only
   function automatic logic [SINE_MAG_WIDTH-1:0] sine_entry(input int k, input int addr_bits);
      longint unsigned half_pi_q30;
      longint unsigned one_q30;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      half_pi_q30 = 64'd1686629713;
      one_q30 = 64'd1 << 30;
      x = (half_pi_q30 * longint'(k) + (64'd1 << (addr_bits - 1))) >> addr_bits;
      x2 = (x * x) >> 30;
      t = one_q30;
      t = one_q30 - ((x2 * t) >> 30) / 156;
      t = one_q30 - ((x2 * t) >> 30) / 110;
      t = one_q30 - ((x2 * t) >> 30) / 72;
      t = one_q30 - ((x2 * t) >> 30) / 42;
      t = one_q30 - ((x2 * t) >> 30) / 20;
      t = one_q30 - ((x2 * t) >> 30) / 6;
      s = (x * t) >> 30;
      s = (s + (64'd1 << 14)) >> 15;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      return SINE_MAG_WIDTH'(s);
   endfunction

   // clamp a sum of two rounded products to the data width
   function automatic logic signed [DATA_WIDTH-1:0] saturate(
      input logic signed [DATA_WIDTH+1:0] value
   );
      logic signed [DATA_WIDTH+1:0] max_val;
      logic signed [DATA_WIDTH+1:0] min_val;
      max_val = (DATA_WIDTH+2)'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
      min_val = -max_val - (DATA_WIDTH+2)'(1);
      if (value > max_val) begin
         return max_val[DATA_WIDTH-1:0];
      end else if (value < min_val) begin
         return min_val[DATA_WIDTH-1:0];
      end
      return value[DATA_WIDTH-1:0];
   endfunction

endpackage

// File: rtl/core/pvr_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvr_sine_rom
// Quarter-wave sine table with two registered read ports, followed by a
// register stage that folds the quadrant and the rotation direction into
// signed sine and cosine.
// ----------------------------------------------------------------------------
module pvr_sine_rom #(
   parameter int TABLE_ADDR_BITS = pvr_pkg::TABLE_ADDR_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic [TABLE_ADDR_BITS+1:0]             angle_idx,
   input  logic                                   negate_sin,
   output logic signed [pvr_pkg::SINE_WIDTH-1:0]  sin_q15,
   output logic signed [pvr_pkg::SINE_WIDTH-1:0]  cos_q15
);
   import pvr_pkg::*;

   localparam int TABLE_SIZE = (1 << TABLE_ADDR_BITS) + 1;
   localparam int ROM_ADDR_W = TABLE_ADDR_BITS + 1;

   logic [SINE_MAG_WIDTH-1:0] sine_rom [TABLE_SIZE];

   logic [TABLE_ADDR_BITS-1:0] k_idx;
   logic [1:0]                 quad;
   logic [ROM_ADDR_W-1:0]      addr_a;
   logic [ROM_ADDR_W-1:0]      addr_b;

   logic [SINE_MAG_WIDTH-1:0]  tab_a_ff;
   logic [SINE_MAG_WIDTH-1:0]  tab_b_ff;
   logic [1:0]                 quad_ff;
   logic                       neg_ff;

   logic [SINE_MAG_WIDTH-1:0]  sin_mag;
   logic [SINE_MAG_WIDTH-1:0]  cos_mag;
   logic                       sin_neg;
   logic                       cos_neg;
   logic signed [SINE_WIDTH-1:0] sin_in;
   logic signed [SINE_WIDTH-1:0] cos_in;
   logic signed [SINE_WIDTH-1:0] sin_ff;
   logic signed [SINE_WIDTH-1:0] cos_ff;

   // constant table contents, built at elaboration
   for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_entry
      localparam logic [SINE_MAG_WIDTH-1:0] ENTRY = sine_entry(g, TABLE_ADDR_BITS);
      assign sine_rom[g] = ENTRY;
   end

   // table addresses: k and N - k
   assign k_idx  = angle_idx[TABLE_ADDR_BITS-1:0];
   assign quad   = angle_idx[TABLE_ADDR_BITS+1:TABLE_ADDR_BITS];
   assign addr_a = {1'b0, k_idx};
   assign addr_b = ROM_ADDR_W'(1 << TABLE_ADDR_BITS) - addr_a;

   // registered table reads
   always_ff @(posedge clock) begin
      tab_a_ff <= sine_rom[addr_a];
      tab_b_ff <= sine_rom[addr_b];
      quad_ff  <= quad;
      neg_ff   <= negate_sin;
   end

   // quadrant folding and sign
   always_comb begin
      sin_mag = quad_ff[0] ? tab_b_ff : tab_a_ff;
      cos_mag = quad_ff[0] ? tab_a_ff : tab_b_ff;
      sin_neg = quad_ff[1] ^ neg_ff;
      cos_neg = quad_ff[1] ^ quad_ff[0];
      sin_in  = sin_neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
      cos_in  = cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
   end

   always_ff @(posedge clock) begin
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   assign sin_q15 = sin_ff;
   assign cos_q15 = cos_ff;

endmodule

// File: rtl/core/park_vector_rotator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// park_vector_rotator
// Forward and inverse Park transform: rotates a Q1.15 vector by minus or
// plus the rotor angle, with table sine/cosine, rounded products and
// saturated results.
// ----------------------------------------------------------------------------
// One request may be taken in every clock cycle while busy is low; its
// response appears with rsp_valid for a single cycle once it has passed
// all stages, in request order. The five stages are the input register, the
// sine table read, the quadrant/sign fold, the four multipliers and the
// round/add/saturate stage. The receiver has no way to hold off a response,
// so nothing in the pipeline ever waits; busy is high only during reset and
// in the first cycle after it. The sine table is a constant ROM and needs
// no loading after reset.
module park_vector_rotator #(
   parameter int TABLE_ADDR_BITS = pvr_pkg::TABLE_ADDR_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pvr_pkg::req_type  req_data,
   output logic              rsp_valid,
   output pvr_pkg::rsp_type  rsp_data
);
   import pvr_pkg::*;

   localparam int IDX_W  = TABLE_ADDR_BITS + 2;
   localparam int PROD_W = DATA_WIDTH + SINE_WIDTH;
   localparam int RND_W  = DATA_WIDTH + 1;
   localparam int SUM_W  = DATA_WIDTH + 2;

   logic                          busy_ff;
   logic                          accept;
   logic [IDX_W-1:0]              angle_idx;

   // stage 0: input register
   logic                          valid0_ff;
   logic                          func0_ff;
   logic signed [DATA_WIDTH-1:0]  x0_ff;
   logic signed [DATA_WIDTH-1:0]  y0_ff;
   logic [IDX_W-1:0]              idx0_ff;

   // stages 1 and 2: vector rides along with the table lookup
   logic                          valid1_ff;
   logic                          valid2_ff;
   logic signed [DATA_WIDTH-1:0]  x1_ff;
   logic signed [DATA_WIDTH-1:0]  y1_ff;
   logic signed [DATA_WIDTH-1:0]  x2_ff;
   logic signed [DATA_WIDTH-1:0]  y2_ff;

   logic signed [SINE_WIDTH-1:0]  sin_q15;
   logic signed [SINE_WIDTH-1:0]  cos_q15;

   // stage 3: products
   logic                          valid3_ff;
   logic signed [PROD_W-1:0]      x_cos_ff;
   logic signed [PROD_W-1:0]      y_sin_ff;
   logic signed [PROD_W-1:0]      x_sin_ff;
   logic signed [PROD_W-1:0]      y_cos_ff;

   // stage 4: round, combine, saturate
   logic signed [PROD_W-1:0]      x_cos_rb;
   logic signed [PROD_W-1:0]      y_sin_rb;
   logic signed [PROD_W-1:0]      x_sin_rb;
   logic signed [PROD_W-1:0]      y_cos_rb;
   logic signed [SUM_W-1:0]       sum_x;
   logic signed [SUM_W-1:0]       sum_y;
   rsp_type                       rsp_in;
   rsp_type                       rsp_ff;
   logic                          rsp_valid_ff;

   // busy covers reset and the cycle after
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // top angle bits address the table
   if (ANGLE_WIDTH >= IDX_W) begin : g_idx_trunc
      assign angle_idx = req_data.angle[ANGLE_WIDTH-1 -: IDX_W];
   end else begin : g_idx_pad
      assign angle_idx = {req_data.angle, (IDX_W - ANGLE_WIDTH)'(0)};
   end

   // stage 0
   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else begin
         valid0_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      func0_ff <= req_data.func;
      x0_ff    <= req_data.in_x;
      y0_ff    <= req_data.in_y;
      idx0_ff  <= angle_idx;
   end

   // forward transform rotates by minus the angle
   pvr_sine_rom #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_sine_rom (
      .clock      (clock),
      .angle_idx  (idx0_ff),
      .negate_sin (func0_ff == FUNC_FORWARD),
      .sin_q15    (sin_q15),
      .cos_q15    (cos_q15)
   );

   // stages 1 and 2
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= valid0_ff;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff <= x0_ff;
      y1_ff <= y0_ff;
      x2_ff <= x1_ff;
      y2_ff <= y1_ff;
   end

   // stage 3: four multipliers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else begin
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_cos_ff <= PROD_W'(x2_ff * cos_q15);
      y_sin_ff <= PROD_W'(y2_ff * sin_q15);
      x_sin_ff <= PROD_W'(x2_ff * sin_q15);
      y_cos_ff <= PROD_W'(y2_ff * cos_q15);
   end

   // round half up, then add and clamp
   always_comb begin
      x_cos_rb = x_cos_ff + PROD_W'(1 << (FRAC_BITS - 1));
      y_sin_rb = y_sin_ff + PROD_W'(1 << (FRAC_BITS - 1));
      x_sin_rb = x_sin_ff + PROD_W'(1 << (FRAC_BITS - 1));
      y_cos_rb = y_cos_ff + PROD_W'(1 << (FRAC_BITS - 1));
      sum_x = SUM_W'($signed(x_cos_rb[PROD_W-1 -: RND_W]))
            - SUM_W'($signed(y_sin_rb[PROD_W-1 -: RND_W]));
      sum_y = SUM_W'($signed(x_sin_rb[PROD_W-1 -: RND_W]))
            + SUM_W'($signed(y_cos_rb[PROD_W-1 -: RND_W]));
      rsp_in.out_x = saturate(sum_x);
      rsp_in.out_y = saturate(sum_y);
   end

   // stage 4: response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/core/pvr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvr_checker
// Port-level checks of the Park vector rotator: fixed latency, no stray
// responses, zero vector in gives zero out, busy released after reset.
// ----------------------------------------------------------------------------
module pvr_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input pvr_pkg::req_type  req_data,
   input logic              rsp_valid,
   input pvr_pkg::rsp_type  rsp_data
);
   import pvr_pkg::*;

   // every accepted request is answered after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("request not answered after pipeline latency");

   // no response without a request at the matching earlier edge
   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("response without a matching request");

   // a zero vector stays zero at any angle
   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.in_x == '0 && req_data.in_y == '0)
      |-> ##LATENCY (rsp_valid && rsp_data.out_x == '0 && rsp_data.out_y == '0))
      else $error("zero vector gave a nonzero result");

   // busy is low whenever reset was low at the previous edge
   a_busy_release: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> !busy)
      else $error("busy high outside reset");

endmodule

bind park_vector_rotator pvr_checker u_pvr_checker (.*);

// File: tb/sv/park_vector_rotator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// park_vector_rotator_checker
// Watches the request and response channels of the Park vector rotator,
// predicts each rotated vector from its own sine table and compares every
// response field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module park_vector_rotator_checker
   import pvr_pkg::*;
#(
   parameter int TABLE_BITS = TABLE_ADDR_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     busy,
   input  req_type  req_data,
   input  logic     rsp_valid,
   input  rsp_type  rsp_data,
   output int       fail_count,
   output int       pending,
   output int       checked_count
);

   localparam int QUARTER = 1 << TABLE_BITS;
   localparam int INDEX_BITS = TABLE_BITS + 2;

   // quarter-wave sine magnitudes, Q1.15, one extra entry for a full quarter
   int sine_q15 [0:QUARTER];
   rsp_type rotated_q [$];

   // fill the sine table: Taylor series of sin in Q30, nested from the top term
   initial begin
      longint unsigned term_div [6];
      longint unsigned one_q30;
      longint unsigned arg;
      longint unsigned arg_sq;
      longint unsigned acc;
      longint unsigned mag;
      term_div = '{156, 110, 72, 42, 20, 6};
      one_q30 = 64'd1 << 30;
      for (int k = 0; k <= QUARTER; k++) begin
         arg = (64'd1686629713 * longint'(k) + longint'(QUARTER / 2)) / longint'(QUARTER);
         arg_sq = (arg * arg) >> 30;
         acc = one_q30;
         foreach (term_div[i]) begin
            acc = one_q30 - ((arg_sq * acc) >> 30) / term_div[i];
         end
         mag = ((arg * acc) >> 30);
         mag = (mag + (64'd1 << 14)) >> 15;
         sine_q15[k] = (mag > 32767) ? 32767 : int'(mag);
      end
   end

   // rounded Q1.15 product, half rounds up
   function automatic longint scale_q15(input longint a, input longint b);
      return (a * b + 64'sd16384) >>> 15;
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] clamp_data(input longint v);
      longint top;
      top = (longint'(1) << (DATA_WIDTH - 1)) - 1;
      if (v > top) begin
         v = top;
      end else if (v < -top - 1) begin
         v = -top - 1;
      end
      return v[DATA_WIDTH-1:0];
   endfunction

   // expected rotated vector for one request
   function automatic rsp_type rotate_vector(input req_type r);
      logic [INDEX_BITS-1:0] phase;
      logic [1:0] quadrant;
      int k;
      int sin_v;
      int cos_v;
      longint vx;
      longint vy;
      rsp_type res;
      phase = INDEX_BITS'(r.angle >> (ANGLE_WIDTH - INDEX_BITS));
      quadrant = phase[INDEX_BITS-1 -: 2];
      k = int'(phase[TABLE_BITS-1:0]);
      case (quadrant)
         2'd0: begin
            sin_v = sine_q15[k];
            cos_v = sine_q15[QUARTER - k];
         end
         2'd1: begin
            sin_v = sine_q15[QUARTER - k];
            cos_v = -sine_q15[k];
         end
         2'd2: begin
            sin_v = -sine_q15[k];
            cos_v = -sine_q15[QUARTER - k];
         end
         default: begin
            sin_v = -sine_q15[QUARTER - k];
            cos_v = sine_q15[k];
         end
      endcase
      // forward transform turns the other way
      if (r.func == FUNC_FORWARD) begin
         sin_v = -sin_v;
      end
      vx = longint'(r.in_x);
      vy = longint'(r.in_y);
      res.out_x = clamp_data(scale_q15(vx, cos_v) - scale_q15(vy, sin_v));
      res.out_y = clamp_data(scale_q15(vx, sin_v) + scale_q15(vy, cos_v));
      return res;
   endfunction

   // compare responses, then queue the prediction for a new request
   always @(posedge clock) begin
      rsp_type want;
      int mismatches;
      if (reset) begin
         rotated_q.delete();
         fail_count <= 0;
         checked_count <= 0;
         pending <= 0;
      end else begin
         if (rsp_valid) begin
            if (rotated_q.size() == 0) begin
               $error("response with no request outstanding: out_x %0d out_y %0d",
                      rsp_data.out_x, rsp_data.out_y);
               fail_count <= fail_count + 1;
            end else begin
               want = rotated_q.pop_front();
               checked_count <= checked_count + 1;
               mismatches = 0;
               if (rsp_data.out_x !== want.out_x) begin
                  $error("out_x mismatch: expected %0d, actual %0d",
                         want.out_x, rsp_data.out_x);
                  mismatches++;
               end
               if (rsp_data.out_y !== want.out_y) begin
                  $error("out_y mismatch: expected %0d, actual %0d",
                         want.out_y, rsp_data.out_y);
                  mismatches++;
               end
               fail_count <= fail_count + mismatches;
            end
         end
         if (start && !busy) begin
            rotated_q.push_back(rotate_vector(req_data));
         end
         pending <= rotated_q.size();
      end
   end

endmodule

// File: tb/sv/park_vector_rotator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// park_vector_rotator_tb
// Drives forward and inverse Park requests into the rotator: a directed set
// of corner vectors and angles, then random requests under several pacing
// phases. A checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module park_vector_rotator_tb;
   import pvr_pkg::*;

   localparam int RANDOM_PER_PHASE = 300;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      checked_count;
   int      forward_sent;
   int      inverse_sent;

   park_vector_rotator u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   park_vector_rotator_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit, far beyond the slowest legal run
   initial begin
      #2ms;
      $display("FAIL");
      $finish;
   end

   function automatic req_type make_request(input logic fn, input int x, input int y,
                                            input int ang);
      req_type r;
      r.func = fn;
      r.in_x = DATA_WIDTH'(x);
      r.in_y = DATA_WIDTH'(y);
      r.angle = ANGLE_WIDTH'(ang);
      return r;
   endfunction

   // component biased toward full scale, zero and minus one
   function automatic int pick_component();
      int corner [4];
      corner = '{-32768, 32767, 0, -1};
      if ($urandom_range(0, 7) == 0) begin
         return corner[$urandom_range(0, 3)];
      end
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   // angle biased toward the quadrant boundaries
   function automatic int pick_angle();
      if ($urandom_range(0, 7) == 0) begin
         return (int'($urandom_range(0, 3)) * 16384 + int'($urandom_range(0, 32)) - 16)
                & 16'hFFFF;
      end
      return int'($urandom_range(0, 65535));
   endfunction

   // present one request and hold it until the block takes it
   task automatic issue_request(input req_type r);
      @(negedge clock);
      start <= 1'b1;
      req_data <= r;
      while (busy) begin
         @(negedge clock);
      end
      if (r.func == FUNC_FORWARD) begin
         forward_sent++;
      end else begin
         inverse_sent++;
      end
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // stimulus and verdict
   initial begin
      req_type corner_set [$];
      int idle_pct [3];
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      forward_sent = 0;
      inverse_sent = 0;
      idle_pct = '{0, 71, 8};

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // corner vectors at unit angles, 45 degree saturation and ignored low angle bits
      corner_set = '{
         make_request(FUNC_FORWARD, 32767, 0, 16'h0000),
         make_request(FUNC_INVERSE, 32767, 0, 16'h0000),
         make_request(FUNC_FORWARD, -32768, -32768, 16'h0000),
         make_request(FUNC_INVERSE, -32768, 32767, 16'h4000),
         make_request(FUNC_FORWARD, -32768, 32767, 16'h4000),
         make_request(FUNC_FORWARD, 32767, -32768, 16'h8000),
         make_request(FUNC_INVERSE, -32768, -32768, 16'h8000),
         make_request(FUNC_FORWARD, 12345, -23456, 16'hC000),
         make_request(FUNC_INVERSE, -32768, 32767, 16'hC000),
         make_request(FUNC_FORWARD, 32767, 32767, 16'h2000),
         make_request(FUNC_INVERSE, 32767, 32767, 16'h2000),
         make_request(FUNC_INVERSE, 32767, -32768, 16'h2000),
         make_request(FUNC_FORWARD, -32768, -32768, 16'h6000),
         make_request(FUNC_INVERSE, -32768, -32768, 16'hE000),
         make_request(FUNC_FORWARD, 1000, -1000, 16'hFFFF),
         make_request(FUNC_INVERSE, 1000, -1000, 16'hFFF0),
         make_request(FUNC_FORWARD, 20000, 5000, 16'h000F),
         make_request(FUNC_INVERSE, 20000, 5000, 16'h3FFF),
         make_request(FUNC_FORWARD, 0, 0, 16'h5A5A),
         make_request(FUNC_INVERSE, 1, 1, 16'h1234),
         make_request(FUNC_FORWARD, -1, 1, 16'hA5A5),
         make_request(FUNC_INVERSE, 1, -1, 16'h7FFF)
      };
      foreach (corner_set[i]) begin
         issue_request(corner_set[i]);
      end

      // random requests under each pacing phase, each cycle idle with the phase's odds
      foreach (idle_pct[p]) begin
         repeat (RANDOM_PER_PHASE) begin
            issue_request(make_request(logic'($urandom_range(0, 1)), pick_component(),
                                       pick_component(), pick_angle()));
            while (int'($urandom_range(0, 99)) < idle_pct[p]) begin
               idle_cycles(1);
            end
         end
      end
      idle_cycles(1);

      // drain, then allow the pipeline depth for any stray response
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 4) @(posedge clock);

      $display("covered %0d forward and %0d inverse requests, %0d responses checked,",
               forward_sent, inverse_sent, checked_count);
      $display("directed corner angles and vectors plus three request pacing phases");
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/pvr_pkg.sv
rtl/core/pvr_sine_rom.sv
rtl/core/park_vector_rotator.sv
rtl/core/pvr_checker.sv
tb/sv/park_vector_rotator_checker.sv
tb/sv/park_vector_rotator_tb.sv
